// ----- hw/rtl/dpfd_pkg.sv -----
// shared types and constants for the dht pulse frame decoder
// no dependencies; imported by every module of the block
package dpfd_pkg;

    // frame geometry
    localparam int FRAME_BITS  = 40;
    localparam int BYTE_W      = 8;
    localparam int BITS_CNT_W  = 6;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_ONE_THRESHOLD       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_CHECK_ENABLE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_NOMINAL        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_TOLERANCE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_SKIP_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_MODE             = 3'd5;

    // configuration reset values
    localparam logic [15:0] RST_BIT_ONE_THRESHOLD       = 16'd100;
    localparam logic        RST_PRESENCE_CHECK_ENABLE   = 1'b0;
    localparam logic [15:0] RST_PRESENCE_NOMINAL        = 16'd160;
    localparam logic [15:0] RST_PRESENCE_TOLERANCE      = 16'd20;
    localparam logic [15:0] RST_RESPONSE_SKIP_THRESHOLD = 16'd150;

    // sensor mode codes
    typedef enum logic [1:0] {
        MODE_AUTO  = 2'd0,
        MODE_DHT11 = 2'd1,
        MODE_DHT22 = 2'd2,
        MODE_RSVD  = 2'd3
    } sensor_mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ABSENT       = 2'd1,
        ST_CHECKSUM     = 2'd2,
        ST_UNDETERMINED = 2'd3
    } status_t;

    // sensor type codes
    localparam logic TYPE_DHT11 = 1'b0;
    localparam logic TYPE_DHT22 = 1'b1;

    // auto detect limits
    localparam logic [BYTE_W-1:0] AUTO_BYTE_LIMIT = 8'd2;
    localparam logic [BYTE_W-1:0] SIGN_MASK       = 8'h80;

    // input request
    typedef struct packed {
        logic [15:0] capture_time;
        logic        frame_start;
    } cap_item_t;

    // result request
    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
        logic               sensor_type;
    } res_item_t;

    // settings seen by the front
    typedef struct packed {
        logic [15:0] bit_one_threshold;
        logic        presence_check_enable;
        logic [15:0] presence_nominal;
        logic [15:0] presence_tolerance;
        logic [15:0] response_skip_threshold;
    } front_cfg_t;

    // kind of frame-end event
    typedef enum logic {
        EV_ABSENT = 1'b0,
        EV_FRAME  = 1'b1
    } event_kind_t;

    // frame-end event passed from front to back
    typedef struct packed {
        event_kind_t           kind;
        logic [FRAME_BITS-1:0] frame;
    } frame_event_t;

endpackage

// ----- hw/rtl/dht_pulse_frame_decoder.sv -----
// top level of the dht pulse frame decoder: settings registers and part wiring
// depends on dpfd_pkg, dpfd_front, dpfd_queue and dpfd_back
//
// Usage
//   cap channel: one timer capture per request, frame_start marks the first
//   capture of a sensor frame. Accepted when cap_valid is high and cap_stall low.
//   res channel: one result per finished frame (status, humidity, temperature,
//   sensor_type). Taken when res_valid is high and res_stall low.
//   cfg channel: register index and data, always ready; write only while idle.
// Throughput: one capture per cycle while cap_stall is low. The front updates
//   interval, bit count and shift register for each accepted capture.
// Path: the event of the capture that ends the frame is registered in the
//   front-to-back queue, then the decoded result in the output register.
// Stall: a stalled result holds in the output register; further frame-end
//   requests wait in a two-entry queue, and cap_stall rises only when it is full.
// Reset: all settings return to their defaults, no frame is active and both
//   the queue and the output register are empty.
module dht_pulse_frame_decoder #(
    parameter int FRAME_CAPTURES = 42
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cap_valid,
    output logic                             cap_stall,
    input  dpfd_pkg::cap_item_t              cap_data,
    output logic                             res_valid,
    input  logic                             res_stall,
    output dpfd_pkg::res_item_t              res_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dpfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);
    import dpfd_pkg::*;

    front_cfg_t   front_cfg_reg;
    sensor_mode_t sensor_mode_reg;

    logic         push_valid;
    logic         queue_full;
    frame_event_t push_data;
    logic         ev_pop;
    logic         ev_valid;
    frame_event_t ev_data;

    // settings registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_cfg_reg.bit_one_threshold       <= RST_BIT_ONE_THRESHOLD;
            front_cfg_reg.presence_check_enable   <= RST_PRESENCE_CHECK_ENABLE;
            front_cfg_reg.presence_nominal        <= RST_PRESENCE_NOMINAL;
            front_cfg_reg.presence_tolerance      <= RST_PRESENCE_TOLERANCE;
            front_cfg_reg.response_skip_threshold <= RST_RESPONSE_SKIP_THRESHOLD;
            sensor_mode_reg                       <= MODE_AUTO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIT_ONE_THRESHOLD:
                    front_cfg_reg.bit_one_threshold <= cfg_data;
                CFG_PRESENCE_CHECK_ENABLE:
                    front_cfg_reg.presence_check_enable <= cfg_data[0];
                CFG_PRESENCE_NOMINAL:
                    front_cfg_reg.presence_nominal <= cfg_data;
                CFG_PRESENCE_TOLERANCE:
                    front_cfg_reg.presence_tolerance <= cfg_data;
                CFG_RESPONSE_SKIP_THRESHOLD:
                    front_cfg_reg.response_skip_threshold <= cfg_data;
                CFG_SENSOR_MODE:
                    sensor_mode_reg <= sensor_mode_t'(cfg_data[1:0]);
                default:
                    sensor_mode_reg <= sensor_mode_reg;
            endcase
        end
    end

    // capture front
    dpfd_front #(
        .FRAME_CAPTURES(FRAME_CAPTURES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (front_cfg_reg),
        .cap_valid (cap_valid),
        .cap_stall (cap_stall),
        .cap_data  (cap_data),
        .push_valid(push_valid),
        .push_full (queue_full),
        .push_data (push_data)
    );

    // frame-end event queue
    dpfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_data(push_data),
        .full     (queue_full),
        .pop      (ev_pop),
        .nonempty (ev_valid),
        .pop_data (ev_data)
    );

    // decode back
    dpfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .sensor_mode(sensor_mode_reg),
        .ev_valid   (ev_valid),
        .ev_data    (ev_data),
        .ev_pop     (ev_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

// ----- hw/rtl/dpfd_front.sv -----
// front part: accepts captures, forms intervals and shifts bits into a frame
// depends on dpfd_pkg; pushes frame-end events into the queue
module dpfd_front #(
    parameter int FRAME_CAPTURES = 42
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpfd_pkg::front_cfg_t cfg,
    input  logic                 cap_valid,
    output logic                 cap_stall,
    input  dpfd_pkg::cap_item_t  cap_data,
    output logic                 push_valid,
    input  logic                 push_full,
    output dpfd_pkg::frame_event_t push_data
);
    import dpfd_pkg::*;

    localparam int IDX_W = $clog2(FRAME_CAPTURES);
    localparam logic [IDX_W-1:0] BUDGET_LAST = IDX_W'(FRAME_CAPTURES - 2);
    localparam logic [BITS_CNT_W-1:0] LAST_BIT = BITS_CNT_W'(FRAME_BITS - 1);

    logic [15:0]           prev_reg, prev_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [BITS_CNT_W-1:0] bits_reg, bits_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic                  active_reg, active_next;

    logic        accept;
    logic [15:0] interval;
    logic        first;
    logic        too_short;
    logic        too_long;
    logic        absent;
    logic        skip;
    logic        bit_val;

    // stall whenever the queue cannot take an event
    assign cap_stall = push_full;
    assign accept    = cap_valid && !cap_stall;

    // interval classification
    assign interval  = cap_data.capture_time - prev_reg;
    assign first     = (idx_reg == '0);
    assign too_short = ({1'b0, interval} + {1'b0, cfg.presence_tolerance})
                       < {1'b0, cfg.presence_nominal};
    assign too_long  = {1'b0, interval}
                       > ({1'b0, cfg.presence_nominal} + {1'b0, cfg.presence_tolerance});
    assign absent    = first && cfg.presence_check_enable && (too_short || too_long);
    assign skip      = first && (interval > cfg.response_skip_threshold);
    assign bit_val   = interval > cfg.bit_one_threshold;

    // frame state update
    always_comb
    begin
        prev_next   = prev_reg;
        idx_next    = idx_reg;
        bits_next   = bits_reg;
        shift_next  = shift_reg;
        active_next = active_reg;
        push_valid  = 1'b0;
        push_data.kind  = EV_FRAME;
        push_data.frame = shift_reg;
        if (accept)
        begin
            if (cap_data.frame_start)
            begin
                prev_next   = cap_data.capture_time;
                idx_next    = '0;
                bits_next   = '0;
                shift_next  = '0;
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                prev_next = cap_data.capture_time;
                idx_next  = idx_reg + 1'b1;
                if (absent)
                begin
                    active_next    = 1'b0;
                    push_valid     = 1'b1;
                    push_data.kind = EV_ABSENT;
                end
                else
                begin
                    if (!skip)
                    begin
                        shift_next = {shift_reg[FRAME_BITS-2:0], bit_val};
                        bits_next  = bits_reg + 1'b1;
                    end
                    push_data.frame = shift_next;
                    if (!skip && (bits_reg == LAST_BIT))
                    begin
                        active_next = 1'b0;
                        push_valid  = 1'b1;
                    end
                    else if (idx_reg >= BUDGET_LAST)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            idx_reg    <= '0;
            bits_reg   <= '0;
            shift_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            prev_reg   <= prev_next;
            idx_reg    <= idx_next;
            bits_reg   <= bits_next;
            shift_reg  <= shift_next;
            active_reg <= active_next;
        end
    end

endmodule

// ----- hw/rtl/dpfd_queue.sv -----
// two-entry queue of frame-end events between front and back
// depends on dpfd_pkg for the event type
module dpfd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  dpfd_pkg::frame_event_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   nonempty,
    output dpfd_pkg::frame_event_t pop_data
);
    import dpfd_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    frame_event_t         slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hw/rtl/dpfd_back.sv -----
// back part: checksum, type selection and value conversion of a frame
// depends on dpfd_pkg; drives the registered result channel
module dpfd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dpfd_pkg::sensor_mode_t sensor_mode,
    input  logic                   ev_valid,
    input  dpfd_pkg::frame_event_t ev_data,
    output logic                   ev_pop,
    output logic                   res_valid,
    input  logic                   res_stall,
    output dpfd_pkg::res_item_t    res_data
);
    import dpfd_pkg::*;

    logic [BYTE_W-1:0] b0, b1, b2, b3, b4;
    logic [BYTE_W-1:0] sum;
    logic              is22;
    logic              undetermined;
    logic [15:0]       hum11;
    logic [15:0]       temp11;
    logic [15:0]       temp22;
    res_item_t         result;

    logic      res_valid_reg, res_valid_next;
    res_item_t res_data_reg, res_data_next;

    // byte split, first received byte is b0
    assign b0 = ev_data.frame[39:32];
    assign b1 = ev_data.frame[31:24];
    assign b2 = ev_data.frame[23:16];
    assign b3 = ev_data.frame[15:8];
    assign b4 = ev_data.frame[7:0];
    assign sum = b0 + b1 + b2 + b3;

    // type selection
    always_comb
    begin
        undetermined = 1'b0;
        is22         = 1'b0;
        unique case (sensor_mode)
            MODE_AUTO:
            begin
                priority if (b0 > AUTO_BYTE_LIMIT)
                    is22 = 1'b0;
                else if ((b2 & SIGN_MASK) != '0)
                    is22 = 1'b1;
                else if ((b1 == '0) && (b3 == '0))
                begin
                    priority if (b2 > AUTO_BYTE_LIMIT)
                        is22 = 1'b0;
                    else if (b0 == AUTO_BYTE_LIMIT)
                        undetermined = 1'b1;
                    else
                        is22 = 1'b1;
                end
                else
                    is22 = 1'b1;
            end
            MODE_DHT22: is22 = 1'b1;
            MODE_DHT11: is22 = 1'b0;
            MODE_RSVD:  is22 = 1'b0;
            default:    is22 = 1'b0;
        endcase
    end

    // value conversion, times ten as shift and add
    assign hum11  = {5'd0, b0, 3'd0} + {7'd0, b0, 1'd0} + {8'd0, b1};
    assign temp11 = {5'd0, b2, 3'd0} + {7'd0, b2, 1'd0} + {8'd0, b3};
    assign temp22 = ((b2 & SIGN_MASK) != '0) ? (16'd0 - {1'b0, b2[6:0], b3})
                                              : {b2, b3};

    // result selection
    always_comb
    begin
        result.status      = ST_OK;
        result.humidity    = '0;
        result.temperature = '0;
        result.sensor_type = TYPE_DHT11;
        priority if (ev_data.kind == EV_ABSENT)
            result.status = ST_ABSENT;
        else if (sum != b4)
            result.status = ST_CHECKSUM;
        else if (undetermined)
            result.status = ST_UNDETERMINED;
        else if (is22)
        begin
            result.humidity    = {b0, b1};
            result.temperature = temp22;
            result.sensor_type = TYPE_DHT22;
        end
        else
        begin
            result.humidity    = hum11;
            result.temperature = temp11;
        end
    end

    // output register loads when empty or being taken
    assign ev_pop = ev_valid && (!res_valid_reg || !res_stall);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (ev_pop)
        begin
            res_valid_next = 1'b1;
            res_data_next  = result;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// ----- tb/dpfd_frame_checker.sv -----
// checker for the dht pulse frame decoder: watches the capture, result and settings channels
// depends on dpfd_pkg; decodes every accepted capture itself and compares the readings
module dpfd_frame_checker #(
    parameter int FRAME_CAPTURES = 42
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cap_valid,
    input  logic                             cap_stall,
    input  dpfd_pkg::cap_item_t              cap_data,
    input  logic                             res_valid,
    input  logic                             res_stall,
    input  dpfd_pkg::res_item_t              res_data,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [dpfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data,
    output int                               mismatches,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import dpfd_pkg::*;

    localparam logic [15:0] DHT11_SCALE = 16'd10;

    // settings as written on the settings channel
    logic [15:0]  one_thr;
    logic         pres_en;
    logic [15:0]  pres_nom;
    logic [15:0]  pres_tol;
    logic [15:0]  skip_thr;
    sensor_mode_t mode_sel;

    // own copy of the frame state
    logic [15:0] last_cap;
    logic [5:0]  ivl_idx;
    logic [5:0]  bit_cnt;
    logic [39:0] bit_shift;
    logic        in_frame;

    res_item_t pending_readings[$];
    res_item_t want;
    res_item_t got;

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // reading of a complete forty-bit frame
    function automatic res_item_t frame_reading();
        logic [7:0]  b0, b1, b2, b3, b4;
        logic [15:0] mag;
        logic        dht22;
        res_item_t   r;
        r = '0;
        r.status = ST_OK;
        {b0, b1, b2, b3, b4} = bit_shift;
        if (8'(b0 + b1 + b2 + b3) != b4)
        begin
            r.status = ST_CHECKSUM;
            return r;
        end
        dht22 = 1'b0;
        case (mode_sel)
            MODE_AUTO:
            begin
                if (b0 > AUTO_BYTE_LIMIT)
                    dht22 = 1'b0;
                else if ((b2 & SIGN_MASK) != '0)
                    dht22 = 1'b1;
                else if (b1 == '0 && b3 == '0)
                begin
                    if (b2 > AUTO_BYTE_LIMIT)
                        dht22 = 1'b0;
                    else if (b0 == AUTO_BYTE_LIMIT)
                    begin
                        r.status = ST_UNDETERMINED;
                        return r;
                    end
                    else
                        dht22 = 1'b1;
                end
                else
                    dht22 = 1'b1;
            end
            MODE_DHT22: dht22 = 1'b1;
            default:    dht22 = 1'b0;
        endcase
        if (dht22)
        begin
            // sign-magnitude temperature turned into two's complement
            mag = {1'b0, b2[6:0], b3};
            r.humidity    = {b0, b1};
            r.temperature = b2[7] ? 16'(-mag) : {b2, b3};
            r.sensor_type = TYPE_DHT22;
        end
        else
        begin
            r.humidity    = b0 * DHT11_SCALE + b1;
            r.temperature = b2 * DHT11_SCALE + b3;
            r.sensor_type = TYPE_DHT11;
        end
        return r;
    endfunction

    // one capture through the frame state; returns 1 when it ends a frame with a reading
    function automatic bit decode_capture(input cap_item_t c, output res_item_t r);
        logic [15:0] iv;
        logic [5:0]  idx;
        bit          take_bit;
        r = '0;
        if (c.frame_start)
        begin
            last_cap  = c.capture_time;
            ivl_idx   = '0;
            bit_cnt   = '0;
            bit_shift = '0;
            in_frame  = 1'b1;
            return 1'b0;
        end
        if (!in_frame)
            return 1'b0;
        iv       = c.capture_time - last_cap;
        last_cap = c.capture_time;
        idx      = ivl_idx;
        ivl_idx  = ivl_idx + 6'd1;
        take_bit = 1'b1;
        // first interval: presence window, then response skip
        if (idx == '0)
        begin
            if (pres_en &&
                (int'(iv) + int'(pres_tol) < int'(pres_nom) ||
                 int'(iv) - int'(pres_tol) > int'(pres_nom)))
            begin
                in_frame = 1'b0;
                r.status = ST_ABSENT;
                return 1'b1;
            end
            if (iv > skip_thr)
                take_bit = 1'b0;
        end
        if (take_bit)
        begin
            bit_shift = {bit_shift[38:0], iv > one_thr};
            bit_cnt   = bit_cnt + 6'd1;
            if (bit_cnt >= FRAME_BITS)
            begin
                in_frame = 1'b0;
                r = frame_reading();
                return 1'b1;
            end
        end
        // capture budget used up
        if (int'(idx) + 1 >= FRAME_CAPTURES - 1)
            in_frame = 1'b0;
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_thr   = RST_BIT_ONE_THRESHOLD;
            pres_en   = RST_PRESENCE_CHECK_ENABLE;
            pres_nom  = RST_PRESENCE_NOMINAL;
            pres_tol  = RST_PRESENCE_TOLERANCE;
            skip_thr  = RST_RESPONSE_SKIP_THRESHOLD;
            mode_sel  = MODE_AUTO;
            last_cap  = '0;
            ivl_idx   = '0;
            bit_cnt   = '0;
            bit_shift = '0;
            in_frame  = 1'b0;
            pending_readings.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // result request against the oldest expected reading
            if (res_valid && !res_stall)
            begin
                if (pending_readings.size() == 0)
                    flag_mismatch($sformatf("result with none expected, status %0d",
                                            res_data.status));
                else
                begin
                    want = pending_readings.pop_front();
                    if (res_data.status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                res_data.status, want.status));
                    if (res_data.humidity !== want.humidity)
                        flag_mismatch($sformatf("humidity %0d, expected %0d",
                                                res_data.humidity, want.humidity));
                    if (res_data.temperature !== want.temperature)
                        flag_mismatch($sformatf("temperature %0d, expected %0d",
                                                res_data.temperature, want.temperature));
                    if (res_data.sensor_type !== want.sensor_type)
                        flag_mismatch($sformatf("sensor_type %0d, expected %0d",
                                                res_data.sensor_type, want.sensor_type));
                end
            end
            // settings write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BIT_ONE_THRESHOLD:       one_thr  = cfg_data;
                    CFG_PRESENCE_CHECK_ENABLE:   pres_en  = cfg_data[0];
                    CFG_PRESENCE_NOMINAL:        pres_nom = cfg_data;
                    CFG_PRESENCE_TOLERANCE:      pres_tol = cfg_data;
                    CFG_RESPONSE_SKIP_THRESHOLD: skip_thr = cfg_data;
                    CFG_SENSOR_MODE:             mode_sel = sensor_mode_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end
            // capture request
            if (cap_valid && !cap_stall)
            begin
                if (decode_capture(cap_data, got))
                    pending_readings.push_back(got);
            end
            outstanding = pending_readings.size();
        end
    end

endmodule

// ----- tb/tb_dht_pulse_frame_decoder.sv -----
// top of the dht pulse frame decoder testbench: clock, reset, capture frames and verdict
// depends on dpfd_pkg, dht_pulse_frame_decoder and dpfd_frame_checker
module tb_dht_pulse_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import dpfd_pkg::*;

    localparam int FRAME_CAPTURES = 42;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 1050;
    localparam int PRESSURE_RUNS  = 30;
    localparam int PHASE_RUNS     = 8;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cap_valid = 1'b0;
    logic                   cap_stall;
    cap_item_t              cap_data  = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_item_t              res_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]            cfg_data  = '0;
    int                     fails;
    int                     pending;

    // settings of the current phase
    logic [15:0]  set_thr  = RST_BIT_ONE_THRESHOLD;
    logic         set_pen  = RST_PRESENCE_CHECK_ENABLE;
    logic [15:0]  set_nom  = RST_PRESENCE_NOMINAL;
    logic [15:0]  set_tol  = RST_PRESENCE_TOLERANCE;
    logic [15:0]  set_skip = RST_RESPONSE_SKIP_THRESHOLD;
    sensor_mode_t set_mode = MODE_AUTO;

    logic [15:0] cur_time      = '0;
    int          items_sent    = 0;
    int          cycle_cnt     = 0;
    bit          no_idle       = 1'b0;
    bit          press_go      = 1'b0;

    dht_pulse_frame_decoder #(
        .FRAME_CAPTURES(FRAME_CAPTURES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap_valid (cap_valid),
        .cap_stall (cap_stall),
        .cap_data  (cap_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dpfd_frame_checker #(
        .FRAME_CAPTURES(FRAME_CAPTURES)
    ) frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cap_valid   (cap_valid),
        .cap_stall   (cap_stall),
        .cap_data    (cap_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (fails),
        .outstanding (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stall after each taken result, one long hold-off on request
    initial
    begin
        int stall_left;
        bit press_done;
        stall_left = 0;
        press_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
            begin
                stall_left = no_idle ? 0 : $urandom_range(5, 0);
            end
            if (press_go && !press_done)
            begin
                press_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            res_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // one capture request; entered and left right after a rising edge
    task automatic put_cap(input logic [15:0] t, input logic st, input bit counted);
        int gap;
        gap = no_idle ? 0 : $urandom_range(5, 0);
        repeat (gap)
        begin
            cap_valid <= 1'b0;
            @(posedge clk);
        end
        cap_valid <= 1'b1;
        cap_data  <= '{capture_time: t, frame_start: st};
        @(posedge clk);
        while (cap_stall)
            @(posedge clk);
        if (counted)
            items_sent++;
    endtask

    task automatic next_cap(input logic [15:0] iv, input bit counted);
        cur_time = cur_time + iv;
        put_cap(cur_time, 1'b0, counted);
    endtask

    task automatic start_frame();
        cur_time = 16'($urandom());
        put_cap(cur_time, 1'b1, 1'b1);
    endtask

    // all results in and the block quiet
    task automatic wait_idle();
        cap_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings();
        logic [CFG_INDEX_W-1:0] idx [6];
        logic [15:0]            val [6];
        idx = '{CFG_BIT_ONE_THRESHOLD, CFG_PRESENCE_CHECK_ENABLE, CFG_PRESENCE_NOMINAL,
                CFG_PRESENCE_TOLERANCE, CFG_RESPONSE_SKIP_THRESHOLD, CFG_SENSOR_MODE};
        val = '{set_thr, 16'(set_pen), set_nom, set_tol, set_skip, 16'(set_mode)};
        wait_idle();
        foreach (idx[k])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // interval that decodes to the given bit under the current threshold
    function automatic logic [15:0] bit_interval(input logic one);
        if (one && set_thr != 16'hFFFF)
            return 16'($urandom_range(65535, int'(set_thr) + 1));
        return 16'($urandom_range(int'(set_thr), 0));
    endfunction

    // response interval: inside the presence window, else mostly above the skip level
    function automatic logic [15:0] first_interval();
        int lo, hi;
        if (set_pen)
        begin
            lo = int'(set_nom) - int'(set_tol);
            hi = int'(set_nom) + int'(set_tol);
            if (lo < 0)
                lo = 0;
            if (hi > 65535)
                hi = 65535;
            return 16'($urandom_range(hi, lo));
        end
        if (set_skip != 16'hFFFF && $urandom_range(3, 0) != 0)
            return 16'($urandom_range(65535, int'(set_skip) + 1));
        return 16'($urandom_range(int'(set_skip), 0));
    endfunction

    // well-formed frame with sensor-like bytes, sometimes a bad checksum
    task automatic good_frame();
        logic [7:0]  b0, b1, b2, b3, b4;
        logic [15:0] v;
        logic [39:0] bits;
        int          top_bit;
        case ($urandom_range(4, 0))
            0:
            begin
                b0 = 8'($urandom_range(95, 3));
                b1 = 8'($urandom_range(9, 0));
                b2 = 8'($urandom_range(50, 0));
                b3 = 8'($urandom_range(9, 0));
            end
            1:
            begin
                v = 16'($urandom_range(1000, 0));
                {b0, b1} = v;
                v = 16'($urandom_range(800, 0));
                {b2, b3} = v;
            end
            2:
            begin
                v = 16'($urandom_range(1000, 0));
                {b0, b1} = v;
                v = 16'($urandom_range(400, 1));
                {b2, b3} = {1'b1, v[14:0]};
            end
            3:
            begin
                // zero fractions around the auto detect limits
                b0 = 8'($urandom_range(2, 0));
                b1 = '0;
                b2 = 8'($urandom_range(5, 0));
                b3 = '0;
            end
            default: {b0, b1, b2, b3} = $urandom();
        endcase
        b4 = b0 + b1 + b2 + b3;
        if ($urandom_range(7, 0) == 0)
            b4 = b4 ^ (8'd1 << $urandom_range(7, 0));
        bits = {b0, b1, b2, b3, b4};
        start_frame();
        v = first_interval();
        next_cap(v, 1'b1);
        // a short first interval already counts as the top bit
        top_bit = (v > set_skip) ? 39 : 38;
        for (int k = top_bit; k >= 0; k--)
            next_cap(bit_interval(bits[k]), 1'b1);
        // captures after the end of the frame
        if ($urandom_range(2, 0) == 0)
            repeat ($urandom_range(3, 1)) next_cap(16'($urandom()), 1'b0);
    endtask

    // start plus a first interval near or off the presence window edges
    task automatic short_frame();
        int v;
        case ($urandom_range(5, 0))
            0:       v = int'(set_nom) - int'(set_tol) - 1;
            1:       v = int'(set_nom) - int'(set_tol);
            2:       v = int'(set_nom) + int'(set_tol);
            3:       v = int'(set_nom) + int'(set_tol) + 1;
            default: v = int'($urandom_range(65535, 0));
        endcase
        start_frame();
        next_cap(16'(v), 1'b1);
        repeat ($urandom_range(3, 0)) next_cap(16'($urandom()), 1'b1);
    endtask

    task automatic run_sequence();
        int kind;
        kind = $urandom_range(9, 0);
        no_idle = ($urandom_range(3, 0) == 0);
        if (kind <= 5)
            good_frame();
        else if (kind <= 7)
            short_frame();
        else if (kind == 8)
        begin
            // broken frame: random intervals, cut short or overlong
            start_frame();
            repeat ($urandom_range(45, 1)) next_cap(16'($urandom()), 1'b1);
        end
        else
            repeat ($urandom_range(3, 1)) put_cap(16'($urandom()), 1'b0, 1'b0);
    endtask

    task automatic pick_settings(input int ph);
        case (ph % 6)
            0:
            begin
                set_thr  = RST_BIT_ONE_THRESHOLD;
                set_pen  = 1'b0;
                set_nom  = RST_PRESENCE_NOMINAL;
                set_tol  = RST_PRESENCE_TOLERANCE;
                set_skip = RST_RESPONSE_SKIP_THRESHOLD;
                set_mode = MODE_AUTO;
            end
            1:
            begin
                set_thr  = RST_BIT_ONE_THRESHOLD;
                set_pen  = 1'b1;
                set_nom  = RST_PRESENCE_NOMINAL;
                set_tol  = RST_PRESENCE_TOLERANCE;
                set_skip = RST_RESPONSE_SKIP_THRESHOLD;
                set_mode = MODE_DHT22;
            end
            2:
            begin
                set_thr  = '0;
                set_pen  = 1'b1;
                set_nom  = '0;
                set_tol  = '0;
                set_skip = '0;
                set_mode = MODE_DHT11;
            end
            3:
            begin
                set_thr  = 16'hFFFF;
                set_pen  = 1'b1;
                set_nom  = 16'hFFFF;
                set_tol  = 16'hFFFF;
                set_skip = 16'hFFFF;
                set_mode = MODE_RSVD;
            end
            default:
            begin
                set_thr  = 16'($urandom());
                set_pen  = 1'($urandom());
                set_nom  = 16'($urandom());
                set_tol  = 16'($urandom_range(3000, 0));
                set_skip = 16'($urandom());
                set_mode = sensor_mode_t'($urandom_range(3, 0));
            end
        endcase
    endtask

    // stimulus and verdict
    initial
    begin
        int ph;
        ph = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: idle capture, skipped response, wrap to a tiny interval
        put_cap(16'hFFFF, 1'b0, 1'b0);
        put_cap(16'h0000, 1'b1, 1'b1);
        put_cap(16'hFFFF, 1'b0, 1'b1);
        put_cap(16'hFFFF, 1'b1, 1'b1);
        put_cap(16'h0000, 1'b0, 1'b1);

        // presence window edges, restart mid-frame, capture after frame end
        set_pen = 1'b1;
        apply_settings();
        put_cap(16'hFFF0, 1'b1, 1'b1);
        put_cap(16'h0084, 1'b0, 1'b1);
        put_cap(16'd100, 1'b1, 1'b1);
        put_cap(16'd239, 1'b0, 1'b1);
        put_cap(16'd500, 1'b0, 1'b0);
        put_cap(16'd1000, 1'b1, 1'b1);
        put_cap(16'd1140, 1'b0, 1'b1);
        put_cap(16'd2000, 1'b1, 1'b1);
        put_cap(16'd2180, 1'b0, 1'b1);
        put_cap(16'd3000, 1'b1, 1'b1);
        put_cap(16'd3181, 1'b0, 1'b1);
        put_cap(16'd4000, 1'b1, 1'b1);
        put_cap(16'd4000, 1'b0, 1'b1);

        // zero tolerance at the top of the nominal range
        set_nom = 16'hFFFF;
        set_tol = '0;
        apply_settings();
        put_cap(16'h0000, 1'b1, 1'b1);
        put_cap(16'hFFFF, 1'b0, 1'b1);
        put_cap(16'h0000, 1'b1, 1'b1);
        put_cap(16'hFFFE, 1'b0, 1'b1);

        // full tolerance around zero nominal
        set_nom = '0;
        set_tol = 16'hFFFF;
        apply_settings();
        put_cap(16'd7, 1'b1, 1'b1);
        put_cap(16'd6, 1'b0, 1'b1);

        // back-pressure: short frames near the presence window edges while the result side holds off
        pick_settings(1);
        apply_settings();
        press_go <= 1'b1;
        repeat (PRESSURE_RUNS) short_frame();

        // random phases
        while (items_sent < ITEM_TARGET)
        begin
            pick_settings(ph);
            apply_settings();
            for (int r = 0; r < PHASE_RUNS && items_sent < ITEM_TARGET; r++)
                run_sequence();
            ph++;
        end

        wait_idle();
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/dpfd_pkg.sv
hw/rtl/dpfd_front.sv
hw/rtl/dpfd_queue.sv
hw/rtl/dpfd_back.sv
hw/rtl/dht_pulse_frame_decoder.sv
tb/dpfd_frame_checker.sv
tb/tb_dht_pulse_frame_decoder.sv
